/* rtl/core/line_follow_steering_controller_top_defines.svh */
// Assertion macros for the line-follow steering controller.
// Used by the top level; expects clk and arst_n in scope.
`ifndef LINE_FOLLOW_STEERING_CONTROLLER_TOP_DEFINES_SVH
`define LINE_FOLLOW_STEERING_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication
`define LFSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LFSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/lfsc_pkg.sv */
// Shared widths, codes, gains and types of the line-follow steering controller.
// No dependencies.
package lfsc_pkg;

	localparam int LEVEL_W     = 12;
	localparam int CENTER_W    = 14;
	localparam int DUTY_W      = 15;
	localparam int ERR_W       = 13;
	localparam int SEG_W       = 2;
	localparam int GAIN_W      = 16;
	localparam int Q_SHIFT     = 16;
	localparam int SUM_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 14;
	localparam int IN_FIELDS_W = 5 * LEVEL_W;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_FIELDS_W = DUTY_W + SEG_W + ERR_W;
	localparam int OUT_TDATA_W = 32;

	localparam logic [SEG_W-1:0] SEG_INIT     = 2'd0;
	localparam logic [SEG_W-1:0] SEG_STRAIGHT = 2'd1;
	localparam logic [SEG_W-1:0] SEG_LEFT     = 2'd2;
	localparam logic [SEG_W-1:0] SEG_RIGHT    = 2'd3;

	localparam logic signed [ERR_W-1:0] SIDE_ERROR  = 13'sd650;
	localparam logic signed [ERR_W-1:0] CORNER_GATE = 13'sd100;

	// Q16 gains
	localparam logic [GAIN_W-1:0] KP_STRAIGHT = 16'd15729;
	localparam logic [GAIN_W-1:0] KD_STRAIGHT = 16'd1311;
	localparam logic [GAIN_W-1:0] KP_CORNER   = 16'd19661;
	localparam logic [GAIN_W-1:0] KD_CORNER   = 16'd3277;

	localparam logic [CFG_IDX_W-1:0] REG_CROSSROAD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CORNER    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STURN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ABSENT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd6;

	typedef struct packed {
		logic [LEVEL_W-1:0]  crossroad_level;
		logic [LEVEL_W-1:0]  corner_level;
		logic [LEVEL_W-1:0]  straight_level;
		logic [LEVEL_W-1:0]  sturn_level;
		logic [LEVEL_W-1:0]  absent_level;
		logic [CENTER_W-1:0] steer_center;
		logic [LEVEL_W-1:0]  steer_limit;
	} cfg_t;

	// left_level in the lowest bits, matching the input tdata layout
	typedef struct packed {
		logic [LEVEL_W-1:0] right_vertical_level;
		logic [LEVEL_W-1:0] left_vertical_level;
		logic [LEVEL_W-1:0] right_level;
		logic [LEVEL_W-1:0] middle_level;
		logic [LEVEL_W-1:0] left_level;
	} sample_t;

endpackage

/* rtl/core/lfsc_cfg.sv */
// Configuration register file of the line-follow steering controller.
// Depends on lfsc_pkg.
module lfsc_cfg import lfsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crossroad_level <= 12'd700;
			cfg_q.corner_level    <= 12'd170;
			cfg_q.straight_level  <= 12'd30;
			cfg_q.sturn_level     <= 12'd400;
			cfg_q.absent_level    <= 12'd10;
			cfg_q.steer_center    <= 14'd1500;
			cfg_q.steer_limit     <= 12'd400;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CROSSROAD: cfg_q.crossroad_level <= cfg_data[LEVEL_W-1:0];
				REG_CORNER:    cfg_q.corner_level    <= cfg_data[LEVEL_W-1:0];
				REG_STRAIGHT:  cfg_q.straight_level  <= cfg_data[LEVEL_W-1:0];
				REG_STURN:     cfg_q.sturn_level     <= cfg_data[LEVEL_W-1:0];
				REG_ABSENT:    cfg_q.absent_level    <= cfg_data[LEVEL_W-1:0];
				REG_CENTER:    cfg_q.steer_center    <= cfg_data[CENTER_W-1:0];
				REG_LIMIT:     cfg_q.steer_limit     <= cfg_data[LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

/* rtl/core/lfsc_seg.sv */
// Next track-segment logic: threshold tests and level comparisons on the sensor set.
// Depends on lfsc_pkg.
module lfsc_seg import lfsc_pkg::*; (
	input  logic [SEG_W-1:0] seg,
	input  sample_t          smp,
	input  cfg_t             cfg,
	output logic [SEG_W-1:0] seg_nxt
);

	logic crossing;
	logic settled;

	always_comb begin
		crossing = (smp.left_vertical_level > cfg.crossroad_level) &&
			(smp.right_vertical_level > cfg.crossroad_level);
		settled = (smp.left_vertical_level < cfg.straight_level) &&
			(smp.right_vertical_level < cfg.straight_level);
		case (seg)
			SEG_INIT: seg_nxt = SEG_STRAIGHT;
			SEG_STRAIGHT: begin
				if (smp.left_vertical_level > cfg.corner_level &&
						smp.right_vertical_level < cfg.straight_level &&
						smp.left_level > cfg.corner_level)
					seg_nxt = SEG_LEFT;
				else if (smp.left_vertical_level < cfg.straight_level &&
						smp.right_vertical_level > cfg.corner_level &&
						smp.right_level > cfg.corner_level)
					seg_nxt = SEG_RIGHT;
				else
					seg_nxt = SEG_STRAIGHT;
			end
			SEG_LEFT: begin
				if (crossing)
					seg_nxt = SEG_STRAIGHT;
				else if (settled && smp.middle_level > smp.right_level &&
						smp.middle_level > smp.left_level)
					seg_nxt = SEG_STRAIGHT;
				else if (smp.right_vertical_level > cfg.sturn_level &&
						smp.left_vertical_level < cfg.absent_level &&
						smp.right_level > cfg.corner_level)
					seg_nxt = SEG_RIGHT;
				else
					seg_nxt = SEG_LEFT;
			end
			default: begin
				if (crossing)
					seg_nxt = SEG_STRAIGHT;
				else if (settled && smp.middle_level > smp.left_level &&
						smp.middle_level > smp.right_level)
					seg_nxt = SEG_STRAIGHT;
				else if (smp.left_vertical_level > cfg.sturn_level &&
						smp.right_vertical_level < cfg.absent_level &&
						smp.left_level > cfg.corner_level)
					seg_nxt = SEG_LEFT;
				else
					seg_nxt = SEG_RIGHT;
			end
		endcase
	end

endmodule

/* rtl/core/lfsc_pd.sv */
// Line error and per-segment PD steering law with truncation and clamp.
// Depends on lfsc_pkg.
module lfsc_pd import lfsc_pkg::*; (
	input  sample_t                  smp,
	input  logic signed [ERR_W-1:0]  prev_err,
	input  logic [SEG_W-1:0]         seg_nxt,
	input  cfg_t                     cfg,
	output logic signed [ERR_W-1:0]  err,
	output logic [DUTY_W-1:0]        duty
);

	localparam int DIFF_W = ERR_W + 1;
	localparam int P_W    = ERR_W + GAIN_W + 1;
	localparam int D_W    = DIFF_W + GAIN_W + 1;
	localparam int CMP_W  = SUM_W - Q_SHIFT + 1;

	logic                     l_wins;
	logic                     r_wins;
	logic signed [DIFF_W-1:0] diff;
	logic [GAIN_W-1:0]        kp;
	logic [GAIN_W-1:0]        kd;
	logic                     apply;
	logic signed [P_W-1:0]    p_term;
	logic signed [D_W-1:0]    d_term;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  sum_adj;
	logic signed [CMP_W-1:0]  pd_duty;
	logic signed [CMP_W-1:0]  hi;
	logic signed [CMP_W-1:0]  lo;
	logic signed [CMP_W-1:0]  sel;
	logic signed [CMP_W-1:0]  clamped;

	always_comb begin
		l_wins = (smp.left_level > smp.middle_level) && (smp.left_level > smp.right_level);
		r_wins = (smp.right_level > smp.middle_level) && (smp.right_level > smp.left_level);
		if (l_wins)
			err = SIDE_ERROR;
		else if (r_wins)
			err = -SIDE_ERROR;
		else
			err = $signed({1'b0, smp.left_level}) - $signed({1'b0, smp.right_level});

		diff = DIFF_W'(err) - DIFF_W'(prev_err);

		case (seg_nxt)
			SEG_LEFT: begin
				apply = err > -CORNER_GATE;
				kp = KP_CORNER;
				kd = KD_CORNER;
			end
			SEG_RIGHT: begin
				apply = err < CORNER_GATE;
				kp = KP_CORNER;
				kd = KD_CORNER;
			end
			SEG_STRAIGHT: begin
				apply = 1'b1;
				kp = KP_STRAIGHT;
				kd = KD_STRAIGHT;
			end
			default: begin
				apply = 1'b0;
				kp = KP_STRAIGHT;
				kd = KD_STRAIGHT;
			end
		endcase

		p_term = P_W'(err) * $signed({1'b0, kp});
		d_term = D_W'(diff) * $signed({1'b0, kd});
		sum = $signed(SUM_W'({cfg.steer_center, Q_SHIFT'(0)})) + SUM_W'(p_term) +
			SUM_W'(d_term);
		// truncate toward zero
		sum_adj = sum[SUM_W-1] ? sum + $signed(SUM_W'((1 << Q_SHIFT) - 1)) : sum;
		pd_duty = CMP_W'($signed(sum_adj[SUM_W-1:Q_SHIFT]));

		hi = $signed(CMP_W'(cfg.steer_center)) + $signed(CMP_W'(cfg.steer_limit));
		lo = $signed(CMP_W'(cfg.steer_center)) - $signed(CMP_W'(cfg.steer_limit));
		sel = apply ? pd_duty : $signed(CMP_W'(cfg.steer_center));
		if (sel > hi)
			clamped = hi;
		else if (sel < lo)
			clamped = lo;
		else
			clamped = sel;
		if (clamped < 0)
			clamped = '0;
		duty = clamped[DUTY_W-1:0];
	end

endmodule

/* rtl/core/line_follow_steering_controller_top.sv */
// Channel   | Dir | Fields (lsb first)
// s_*       | in  | tdata: left, middle, right, left_vertical, right_vertical (12b each)
// m_*       | out | tdata: servo_duty 15b, track_segment 2b, line_error 13b signed
// cfg_*     | in  | cfg_index 3b, cfg_data 14b; always ready
// One sensor set per cycle sustained while m_tready is high; a taken request reaches m_* through
// the input register, one combinational pass (segment logic, two parallel gain multiplies,
// adder, clamp), result register. Segment and last error update as an item moves to
// the result register. Reset clears valids, segment to init, last error to zero.
// A stalled result holds; the input register takes a request while it is empty or
// its item moves on to the result register.
// Depends on lfsc_pkg, lfsc_cfg, lfsc_seg, lfsc_pd and the assertion macro header.
`include "line_follow_steering_controller_top_defines.svh"

module line_follow_steering_controller_top import lfsc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// left, middle, right, left_vertical, right_vertical; [63:60] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// servo_duty, track_segment, line_error; [31:30] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t                    cfg;
	logic                    valid_s1;
	sample_t                 sample_s1;
	logic                    valid_s2;
	logic [DUTY_W-1:0]       duty_s2;
	logic [SEG_W-1:0]        seg_s2;
	logic signed [ERR_W-1:0] err_s2;
	logic [SEG_W-1:0]        seg_q;
	logic signed [ERR_W-1:0] prev_err_q;
	logic [SEG_W-1:0]        seg_nxt;
	logic signed [ERR_W-1:0] err;
	logic [DUTY_W-1:0]       duty;
	logic                    adv_s1;
	logic [DUTY_W-1:0]       duty_hi;
	logic                    left_gated;
	logic                    center_out;
	logic                    state_match;

	lfsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lfsc_seg u_seg (
		.seg     (seg_q),
		.smp     (sample_s1),
		.cfg     (cfg),
		.seg_nxt (seg_nxt)
	);

	lfsc_pd u_pd (
		.smp      (sample_s1),
		.prev_err (prev_err_q),
		.seg_nxt  (seg_nxt),
		.cfg      (cfg),
		.err      (err),
		.duty     (duty)
	);

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_TDATA_W'({err_s2, seg_s2, duty_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			seg_q      <= SEG_INIT;
			prev_err_q <= '0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (!valid_s2 || m_tready)
				valid_s2 <= valid_s1;
			if (adv_s1) begin
				seg_q      <= seg_nxt;
				prev_err_q <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			sample_s1 <= s_tdata[IN_FIELDS_W-1:0];
		if (adv_s1) begin
			duty_s2 <= duty;
			seg_s2  <= seg_nxt;
			err_s2  <= err;
		end
	end

	assign duty_hi     = DUTY_W'(cfg.steer_center) + DUTY_W'(cfg.steer_limit);
	assign left_gated  = valid_s2 && seg_s2 == SEG_LEFT && err_s2 <= -CORNER_GATE;
	assign center_out  = duty_s2 == DUTY_W'(cfg.steer_center);
	assign state_match = seg_q == seg_s2 && prev_err_q == err_s2;

	`LFSC_ASSERT_NOW(a_seg_not_init, valid_s2, seg_s2 != SEG_INIT, "init segment reported")
	`LFSC_ASSERT_NOW(a_duty_max, valid_s2, duty_s2 <= duty_hi, "duty above center plus limit")
	`LFSC_ASSERT_NOW(a_left_gate, left_gated, center_out, "gated left corner not at center")
	`LFSC_ASSERT_NEXT(a_state_track, adv_s1, state_match, "state out of step with result")

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for line_follow_steering_controller_top.
// Directed and random sensor sets go in, each steering result is predicted or given and
// compared in order. Depends on lfsc_pkg and the RTL top.
module tb_top;
	import lfsc_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 125;
	localparam longint Q_ONE = 1 << Q_SHIFT;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [ERR_W-1:0]  err;
		logic [SEG_W-1:0]  seg;
		logic [DUTY_W-1:0] duty;
	} steer_result_t;

	typedef struct packed {
		bit                    is_write;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		sample_t               levels;
		bit                    typed;
		steer_result_t         want;
	} drill_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_CROSSROAD;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	cfg_t             regs;
	logic [SEG_W-1:0] track = SEG_INIT;
	int               last_err = 0;
	steer_result_t    pending_steer[$];
	drill_t           drill[$];
	steer_result_t    blank;
	int               fails = 0;
	int               hold = 1;
	int               quiet = 0;
	bit               src_idle = 1'b1;
	bit               sink_stall = 1'b1;

	line_follow_steering_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic steer_result_t predict_steering(input sample_t s);
		int l, m, r, lv, rv, cr, cn, st, sn, ab, ctr, lim;
		int err, diff, duty, hi, lo, gate;
		bit crossing, settled, apply;
		longint kp, kd, acc;
		steer_result_t res;
		l = int'(s.left_level);
		m = int'(s.middle_level);
		r = int'(s.right_level);
		lv = int'(s.left_vertical_level);
		rv = int'(s.right_vertical_level);
		cr = int'(regs.crossroad_level);
		cn = int'(regs.corner_level);
		st = int'(regs.straight_level);
		sn = int'(regs.sturn_level);
		ab = int'(regs.absent_level);
		ctr = int'(regs.steer_center);
		lim = int'(regs.steer_limit);
		gate = int'(CORNER_GATE);
		crossing = lv > cr && rv > cr;
		settled = lv < st && rv < st;
		case (track)
			SEG_INIT: track = SEG_STRAIGHT;
			SEG_STRAIGHT: begin
				if (lv > cn && rv < st && l > cn)
					track = SEG_LEFT;
				else if (lv < st && rv > cn && r > cn)
					track = SEG_RIGHT;
			end
			SEG_LEFT: begin
				if (crossing || (settled && m > r && m > l))
					track = SEG_STRAIGHT;
				else if (rv > sn && lv < ab && r > cn)
					track = SEG_RIGHT;
			end
			default: begin
				if (crossing || (settled && m > l && m > r))
					track = SEG_STRAIGHT;
				else if (lv > sn && rv < ab && l > cn)
					track = SEG_LEFT;
			end
		endcase

		if (l > m && l > r)
			err = int'(SIDE_ERROR);
		else if (r > m && r > l)
			err = -int'(SIDE_ERROR);
		else
			err = l - r;
		diff = err - last_err;

		kp = longint'(KP_CORNER);
		kd = longint'(KD_CORNER);
		case (track)
			SEG_STRAIGHT: begin
				apply = 1'b1;
				kp = longint'(KP_STRAIGHT);
				kd = longint'(KD_STRAIGHT);
			end
			SEG_LEFT: apply = err > -gate;
			default: apply = err < gate;
		endcase

		if (apply) begin
			acc = longint'(ctr) * Q_ONE + longint'(err) * kp + longint'(diff) * kd;
			duty = int'(acc / Q_ONE);
		end else begin
			duty = ctr;
		end
		hi = ctr + lim;
		lo = ctr - lim;
		if (duty > hi)
			duty = hi;
		else if (duty < lo)
			duty = lo;
		if (duty < 0)
			duty = 0;

		last_err = err;
		res.duty = duty[DUTY_W-1:0];
		res.seg = track;
		res.err = err[ERR_W-1:0];
		return res;
	endfunction

	function automatic void add_row(input int l, m, r, lv, rv, input bit typed,
		input int duty, input logic [SEG_W-1:0] seg, input int err);
		drill_t row;
		row = '0;
		row.levels.left_level = l[LEVEL_W-1:0];
		row.levels.middle_level = m[LEVEL_W-1:0];
		row.levels.right_level = r[LEVEL_W-1:0];
		row.levels.left_vertical_level = lv[LEVEL_W-1:0];
		row.levels.right_vertical_level = rv[LEVEL_W-1:0];
		row.typed = typed;
		row.want.duty = duty[DUTY_W-1:0];
		row.want.seg = seg;
		row.want.err = err[ERR_W-1:0];
		drill.push_back(row);
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input int val);
		drill_t row;
		row = '0;
		row.is_write = 1'b1;
		row.idx = idx;
		row.val = val[CFG_DATA_W-1:0];
		drill.push_back(row);
	endfunction

	function automatic logic [LEVEL_W-1:0] loose_level();
		if ($urandom_range(0, 1) != 0)
			return LEVEL_W'($urandom_range(0, 4095));
		return LEVEL_W'($urandom_range(0, 300));
	endfunction

	function automatic sample_t random_levels();
		int kind;
		sample_t s;
		kind = $urandom_range(0, 9);
		s.left_level = loose_level();
		s.middle_level = loose_level();
		s.right_level = loose_level();
		s.left_vertical_level = LEVEL_W'($urandom_range(0, 40));
		s.right_vertical_level = LEVEL_W'($urandom_range(0, 40));
		case (kind)
			2: begin
				s.left_vertical_level = LEVEL_W'($urandom_range(150, 4095));
				s.left_level = LEVEL_W'($urandom_range(150, 4095));
			end
			3: begin
				s.right_vertical_level = LEVEL_W'($urandom_range(150, 4095));
				s.right_level = LEVEL_W'($urandom_range(150, 4095));
			end
			4: begin
				s.left_vertical_level = LEVEL_W'($urandom_range(600, 4095));
				s.right_vertical_level = LEVEL_W'($urandom_range(600, 4095));
			end
			5: begin
				s.right_vertical_level = LEVEL_W'($urandom_range(300, 4095));
				s.left_vertical_level = LEVEL_W'($urandom_range(0, 15));
				s.right_level = LEVEL_W'($urandom_range(150, 4095));
			end
			6: begin
				s.left_vertical_level = LEVEL_W'($urandom_range(300, 4095));
				s.right_vertical_level = LEVEL_W'($urandom_range(0, 15));
				s.left_level = LEVEL_W'($urandom_range(150, 4095));
			end
			7: begin
				s.middle_level = LEVEL_W'($urandom_range(200, 4095));
				s.left_level = LEVEL_W'($urandom_range(0, 200));
				s.right_level = LEVEL_W'($urandom_range(0, 200));
			end
			8, 9: begin
				s.left_vertical_level = LEVEL_W'($urandom_range(0, 4095));
				s.right_vertical_level = LEVEL_W'($urandom_range(0, 4095));
				s.left_level = LEVEL_W'($urandom_range(0, 4095));
				s.middle_level = LEVEL_W'($urandom_range(0, 4095));
				s.right_level = LEVEL_W'($urandom_range(0, 4095));
			end
			default: ;
		endcase
		return s;
	endfunction

	task automatic drain_results();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		while (pending_steer.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		logic [CFG_DATA_W-1:0] v;
		v = val[CFG_DATA_W-1:0];
		drain_results();
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CROSSROAD: regs.crossroad_level = v[LEVEL_W-1:0];
			REG_CORNER:    regs.corner_level = v[LEVEL_W-1:0];
			REG_STRAIGHT:  regs.straight_level = v[LEVEL_W-1:0];
			REG_STURN:     regs.sturn_level = v[LEVEL_W-1:0];
			REG_ABSENT:    regs.absent_level = v[LEVEL_W-1:0];
			REG_CENTER:    regs.steer_center = v;
			REG_LIMIT:     regs.steer_limit = v[LEVEL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_levels(input sample_t s, input bit typed, input steer_result_t want);
		steer_result_t model_out;
		int gap;
		if (cfg_valid)
			cfg_valid <= 1'b0;
		s_tdata <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, s};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		model_out = predict_steering(s);
		pending_steer.push_back(typed ? want : model_out);
		gap = src_idle ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_settings(input int phase);
		int cr, cn, st, sn, ab, ctr, lim;
		cr = 700;
		cn = 170;
		st = 30;
		sn = 400;
		ab = 10;
		ctr = 1500;
		lim = 400;
		case (phase)
			0: ;
			1: begin
				cr = 0; cn = 0; st = 0; sn = 0; ab = 0;
				ctr = $urandom_range(0, 16383);
				lim = $urandom_range(0, 4095);
			end
			2: begin
				cr = 4095; cn = 4095; st = 4095; sn = 4095; ab = 4095;
				ctr = 16383;
				lim = 4095;
			end
			3: begin
				ctr = 0;
				lim = 0;
			end
			4: begin
				ctr = $urandom_range(0, 2000);
				lim = 4095;
			end
			default: begin
				cr = $urandom_range(400, 1500);
				cn = $urandom_range(100, 300);
				st = $urandom_range(10, 60);
				sn = $urandom_range(250, 600);
				ab = $urandom_range(0, 20);
				ctr = $urandom_range(0, 16383);
				lim = $urandom_range(0, 4095);
			end
		endcase
		write_reg(REG_CROSSROAD, cr);
		write_reg(REG_CORNER, cn);
		write_reg(REG_STRAIGHT, st);
		write_reg(REG_STURN, sn);
		write_reg(REG_ABSENT, ab);
		write_reg(REG_CENTER, ctr);
		write_reg(REG_LIMIT, lim);
	endtask

	task automatic check_steer(input logic [OUT_TDATA_W-1:0] word);
		steer_result_t got, want;
		got = word[OUT_FIELDS_W-1:0];
		if (pending_steer.size() == 0) begin
			fails++;
			$display("%0t: result with no request pending: duty %0d seg %0d err %0d",
				$time, got.duty, got.seg, $signed(got.err));
		end else begin
			want = pending_steer.pop_front();
			if (got.duty !== want.duty) begin
				fails++;
				$display("%0t: servo_duty expected %0d, got %0d", $time, want.duty, got.duty);
			end
			if (got.seg !== want.seg) begin
				fails++;
				$display("%0t: track_segment expected %0d, got %0d", $time, want.seg, got.seg);
			end
			if (got.err !== want.err) begin
				fails++;
				$display("%0t: line_error expected %0d, got %0d", $time,
					$signed(want.err), $signed(got.err));
			end
		end
	endtask

	// result side: random back-pressure after each accepted result while sink_stall is set
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				check_steer(m_tdata);
				hold = sink_stall ? $urandom_range(0, 8) : 0;
				if (hold != 0)
					m_tready <= 1'b0;
			end else if (!m_tready) begin
				if (hold <= 1)
					m_tready <= 1'b1;
				hold = hold - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		blank = '0;
		regs.crossroad_level = 700;
		regs.corner_level = 170;
		regs.straight_level = 30;
		regs.sturn_level = 400;
		regs.absent_level = 10;
		regs.steer_center = 1500;
		regs.steer_limit = 400;

		// levels l, m, r, lv, rv; then typed flag and the known result
		add_row(0, 0, 0, 0, 0, 1, 1500, SEG_STRAIGHT, 0);
		add_row(4095, 0, 0, 0, 0, 0, 0, SEG_INIT, 0);
		add_row(0, 0, 4095, 0, 0, 0, 0, SEG_INIT, 0);
		add_row(4095, 4095, 0, 0, 0, 1, 1900, SEG_STRAIGHT, 4095);
		add_row(0, 4095, 4095, 0, 0, 1, 1100, SEG_STRAIGHT, -4095);
		// crossing seen while straight
		add_row(4095, 4095, 4095, 4095, 4095, 0, 0, SEG_INIT, 0);
		add_row(300, 200, 100, 500, 0, 0, 0, SEG_INIT, 0);
		// left corner, error on the wrong side and at the gate
		add_row(0, 0, 300, 500, 0, 1, 1500, SEG_LEFT, -650);
		add_row(0, 300, 100, 500, 0, 1, 1500, SEG_LEFT, -100);
		add_row(0, 300, 99, 500, 0, 0, 0, SEG_INIT, 0);
		add_row(0, 0, 300, 0, 500, 0, 0, SEG_INIT, 0);
		add_row(300, 0, 0, 0, 500, 1, 1500, SEG_RIGHT, 650);
		add_row(100, 300, 0, 0, 500, 1, 1500, SEG_RIGHT, 100);
		add_row(300, 0, 0, 500, 0, 0, 0, SEG_INIT, 0);
		add_row(100, 300, 100, 0, 0, 0, 0, SEG_INIT, 0);
		add_row(0, 100, 300, 0, 500, 0, 0, SEG_INIT, 0);
		add_row(0, 0, 0, 4095, 4095, 0, 0, SEG_INIT, 0);
		// low clamp goes negative, duty floors at zero; limit write is masked
		add_write(REG_CENTER, 0);
		add_write(REG_LIMIT, 16383);
		add_row(0, 0, 4095, 0, 0, 1, 0, SEG_STRAIGHT, -650);
		add_write(REG_CENTER, 16383);
		add_write(REG_UNUSED, 16383);
		add_row(4095, 0, 0, 0, 0, 0, 0, SEG_INIT, 0);
		add_row(4095, 4095, 0, 0, 0, 0, 0, SEG_INIT, 0);
		add_write(REG_LIMIT, 0);
		add_row(4095, 0, 0, 0, 0, 1, 16383, SEG_STRAIGHT, 650);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (drill[i]) begin
			if (drill[i].is_write)
				write_reg(drill[i].idx, int'(drill[i].val));
			else
				send_levels(drill[i].levels, drill[i].typed, drill[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			load_settings(p);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) begin
					src_idle = $urandom_range(0, 2) != 0;
					sink_stall = $urandom_range(0, 2) != 0;
				end
				if ($urandom_range(0, 63) == 0)
					drain_results();
				send_levels(random_levels(), 1'b0, blank);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* line_follow_steering_controller_top.f */
+incdir+rtl/core
rtl/core/lfsc_pkg.sv
rtl/core/lfsc_cfg.sv
rtl/core/lfsc_seg.sv
rtl/core/lfsc_pd.sv
rtl/core/line_follow_steering_controller_top.sv
tb/sv/tb_top.sv
